// ===== sv/mdbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mdbf_pkg: shared types and constants
// Item layouts, register indexes, history sizing and the back-end state
// type of the mesh duplicate broadcast filter.
// ----------------------------------------------------------------------------
package mdbf_pkg;

  // History and known-sender sizing
  localparam int HISTORY_DEPTH = 16;
  localparam int KNOWN_SENDERS = 4;
  localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_IW = (KNOWN_SENDERS > 1) ? $clog2(KNOWN_SENDERS) : 1;
  localparam int SENDER_REGS = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // Payload minimum and special codes
  localparam logic [7:0]  MIN_PAYLOAD  = 8'd8;
  localparam logic [2:0]  UNKNOWN_SLOT = 3'd4;
  localparam logic [0:0]  CMD_RECEIVE  = 1'b0;
  localparam logic [0:0]  CMD_RECORD   = 1'b1;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BCAST    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SENDER_A = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SENDER_B = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SENDER_C = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SENDER_D = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_COLORS   = 3'd6;

  // Register reset values
  localparam logic [15:0] BCAST_RESET = 16'hFFFF;
  localparam logic [14:0] COLOR_RESET = 15'h5C54;
  localparam logic [SENDER_REGS-1:0][15:0] SENDER_RESET =
    {16'h5384, 16'hCD00, 16'h7200, 16'h8C18};

  // Input item
  typedef struct packed {
    logic [0:0]  cmd;
    logic [15:0] packet_destination;
    logic [31:0] payload_counter;
    logic [31:0] payload_sender;
    logic [7:0]  payload_size;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        is_unique;
    logic        retransmit;
    logic        size_error;
    logic        indicate;
    logic [2:0]  led_color;
    logic [2:0]  sender_slot;
    logic [15:0] sender_count;
    logic [15:0] concentrator_address;
  } res_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic        record;    // own broadcast, store without check
    logic        check;     // look up in history
    logic        retx_ok;   // endpoint mode
    logic        is_bcast;
    logic        size_ok;
    logic [2:0]  slot;
    logic [2:0]  color;
    logic [15:0] sender16;
    logic [63:0] pair;      // {sender, counter}
  } job_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_e;

  // Advance a history index with wrap
  function automatic logic [HIST_AW-1:0] hist_inc(input logic [HIST_AW-1:0] ptr);
    logic [HIST_AW-1:0] nxt;
    if (ptr == HIST_AW'(HISTORY_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== sv/mdbf_front.sv =====
// ----------------------------------------------------------------------------
// mdbf_front: register file, classifier and item queue
// Holds the configuration registers, classifies each accepted item (history
// check, size, known-sender slot and color) and queues it for the back end.
// ----------------------------------------------------------------------------
module mdbf_front import mdbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              push_i,
  output logic              full_o,
  input  in_item_t          item_i,
  output logic              job_vld_o,
  input  logic              job_take_i,
  output job_t              job_o
);

  logic                         mode_q;
  logic [15:0]                  bcast_q;
  logic [SENDER_REGS-1:0][15:0] sender_q;
  logic [14:0]                  colors_q;

  job_t                         fifo_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]          wptr_q, rptr_q;
  logic [QUEUE_CW-1:0]          cnt_q;
  job_t                         job_d;
  logic                         wr_en, rd_en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      bcast_q  <= BCAST_RESET;
      sender_q <= SENDER_RESET;
      colors_q <= COLOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     mode_q      <= cfg_wdata_i[0];
        CFG_BCAST:    bcast_q     <= cfg_wdata_i;
        CFG_SENDER_A: sender_q[0] <= cfg_wdata_i;
        CFG_SENDER_B: sender_q[1] <= cfg_wdata_i;
        CFG_SENDER_C: sender_q[2] <= cfg_wdata_i;
        CFG_SENDER_D: sender_q[3] <= cfg_wdata_i;
        CFG_COLORS:   colors_q    <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Classification
  always_comb begin
    job_d          = '0;
    job_d.record   = (item_i.cmd == CMD_RECORD);
    job_d.is_bcast = (item_i.packet_destination == bcast_q);
    job_d.check    = (item_i.cmd == CMD_RECEIVE) && (mode_q || job_d.is_bcast);
    job_d.retx_ok  = !mode_q;
    job_d.size_ok  = (item_i.payload_size >= MIN_PAYLOAD);
    job_d.sender16 = item_i.payload_sender[15:0];
    job_d.pair     = {item_i.payload_sender, item_i.payload_counter};
    job_d.slot     = UNKNOWN_SLOT;
    job_d.color    = colors_q[14:12];
    // lowest matching slot wins: scan downward
    for (int i = KNOWN_SENDERS - 1; i >= 0; i--) begin
      if (sender_q[i] == item_i.payload_sender[15:0]) begin
        job_d.slot  = 3'(i);
        job_d.color = colors_q[3*i +: 3];
      end
    end
  end

  // Item queue
  assign full_o    = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign job_vld_o = (cnt_q != '0);
  assign wr_en     = push_i && !full_o;
  assign rd_en     = job_take_i && job_vld_o;
  assign job_o     = fifo_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd_en) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wptr_q] <= job_d;
    end
  end

endmodule

// ===== sv/mdbf_back.sv =====
// ----------------------------------------------------------------------------
// mdbf_back: history scan and state update
// Scans the seen-pair history one entry per cycle, then stores new pairs,
// updates the learned concentrator and sender counters and fills the
// one-entry result register.
// ----------------------------------------------------------------------------
module mdbf_back import mdbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_vld_i,
  output logic      job_take_o,
  input  job_t      job_i,
  output logic      empty_o,
  input  logic      pop_i,
  output res_item_t result_o
);

  back_state_e                state_q, state_d;
  job_t                       job_q, job_d;
  logic [HIST_AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]          rd_cnt_q, rd_cnt_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic                       hit_q, hit_d;
  logic [63:0]                rd_data_q;
  logic [63:0]                hist_mem [HISTORY_DEPTH];

  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [HIST_AW-1:0]         oldest_q, oldest_d;
  logic [15:0]                conc_q, conc_d;
  logic [KNOWN_SENDERS-1:0][15:0] counts_q, counts_d;
  logic                       out_vld_q, out_vld_d;
  res_item_t                  out_q, out_d;

  logic                       issue, match, out_free;
  logic                       mem_we;
  logic [HIST_AW-1:0]         wr_idx;
  logic [FILL_W:0]            wr_sum;
  logic                       is_unique, do_store, show;
  logic [SLOT_IW-1:0]         slot_idx;
  logic [15:0]                cnt_inc;

  // History write slot: next free entry, or the oldest once full
  always_comb begin
    wr_sum = (FILL_W + 1)'(oldest_q) + (FILL_W + 1)'(fill_q);
    if (wr_sum >= (FILL_W + 1)'(HISTORY_DEPTH)) begin
      wr_sum = wr_sum - (FILL_W + 1)'(HISTORY_DEPTH);
    end
    if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
      wr_idx = wr_sum[HIST_AW-1:0];
    end else begin
      wr_idx = oldest_q;
    end
  end

  assign issue    = (rd_cnt_q < fill_q);
  assign match    = cmp_vld_q && (rd_data_q == job_q.pair);
  assign out_free = !out_vld_q || pop_i;
  assign slot_idx = job_q.slot[SLOT_IW-1:0];
  assign cnt_inc  = counts_q[slot_idx] + 16'd1;

  // Outcome of the finished item
  assign is_unique = !job_q.record && (!job_q.check || !hit_q);
  assign do_store  = job_q.record || (job_q.check && !hit_q);
  assign show      = is_unique && job_q.size_ok;

  // Sequencer: next state, scan control, state update and result
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    rd_ptr_d   = rd_ptr_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    hit_d      = hit_q;
    fill_d     = fill_q;
    oldest_d   = oldest_q;
    conc_d     = conc_q;
    counts_d   = counts_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_d      = out_q;
    job_take_o = 1'b0;
    mem_we     = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (job_vld_i) begin
          job_take_o = 1'b1;
          job_d      = job_i;
          rd_ptr_d   = oldest_q;
          rd_cnt_d   = '0;
          hit_d      = 1'b0;
          state_d    = job_i.check ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = B_DONE;
        end else if (issue) begin
          rd_ptr_d  = hist_inc(rd_ptr_q);
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d   = B_IDLE;
          out_vld_d = 1'b1;
          // history store
          if (do_store) begin
            mem_we = 1'b1;
            if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
              fill_d = fill_q + 1'b1;
            end else begin
              oldest_d = hist_inc(oldest_q);
            end
          end
          // result fields
          out_d.is_unique    = is_unique;
          out_d.retransmit   = is_unique && job_q.check && job_q.retx_ok;
          out_d.size_error   = is_unique && !job_q.size_ok;
          out_d.indicate     = show;
          out_d.led_color    = show ? job_q.color : 3'd0;
          out_d.sender_slot  = UNKNOWN_SLOT;
          out_d.sender_count = '0;
          if (show && job_q.is_bcast) begin
            conc_d = job_q.sender16;
          end
          if (show && job_q.slot != UNKNOWN_SLOT) begin
            counts_d[slot_idx] = cnt_inc;
            out_d.sender_slot  = job_q.slot;
            out_d.sender_count = cnt_inc;
          end
          out_d.concentrator_address = conc_d;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      rd_ptr_q  <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      fill_q    <= '0;
      oldest_q  <= '0;
      conc_q    <= BCAST_RESET;
      counts_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      conc_q    <= conc_d;
      counts_q  <= counts_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  // History memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_idx] <= job_q.pair;
    end
    rd_data_q <= hist_mem[rd_ptr_q];
  end

  assign empty_o  = !out_vld_q;
  assign result_o = out_q;

endmodule

// ===== sv/mesh_duplicate_broadcast_filter.sv =====
// ----------------------------------------------------------------------------
// mesh_duplicate_broadcast_filter: duplicate packet suppression for a mesh node
// Queue-style front end that classifies packets, and a back end that checks
// them against a FIFO history of seen (counter, sender) pairs.
// ----------------------------------------------------------------------------
// One item is worked at a time in the back end. An item that skips the
// history check goes from idle straight to the done state; a scanned item
// first passes the scan state, which reads one history entry per cycle
// through a registered memory read, and a hit ends the scan early.
// A finished item also waits while the previous result is still unpopped.
// A two-entry queue after the classifier takes new items while the back end
// is busy, and a one-entry result register holds a finished result until it
// is popped. History entries are valid through a fill count, so no clearing
// pass runs after reset. Registers must be written only while the block is
// idle; the block itself does not enforce this.
module mesh_duplicate_broadcast_filter import mdbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  in_item_t          item_i,
  output logic              empty,
  input  logic              pop,
  output res_item_t         result_o
);

  logic job_vld, job_take;
  job_t job;

  // Front: registers, classifier, queue
  mdbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .job_vld_o   (job_vld),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  // Back: history scan and update
  mdbf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_vld_i  (job_vld),
    .job_take_o (job_take),
    .job_i      (job),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

  // Retransmit only for unique packets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!result_o.retransmit || result_o.is_unique))
    else $error("retransmit on a dropped packet");

  // Size error and indication are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.size_error && result_o.indicate))
    else $error("size error with indication");

  // Unknown slot carries no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.sender_slot == UNKNOWN_SLOT) |-> result_o.sender_count == '0)
    else $error("count on unknown sender");

  // Back end takes an item only when the queue has one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_vld)
    else $error("take from empty queue");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for mesh_duplicate_broadcast_filter
// Drives packets and own-broadcast records through the queue-style ports,
// predicts every verdict with a local model of the seen-pair history, known
// sender slots and learned concentrator, and compares each popped verdict
// field by field. Covers directed corner cases, register extremes, random
// traffic under several idle/stall profiles, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import mdbf_pkg::*;

  // Register index past the end of the map; writes there must be ignored
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
  localparam int RECENT_MAX = 24;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_idx   = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              push      = 1'b0;
  logic              full;
  in_item_t          pkt       = '0;
  logic              empty;
  logic              pop       = 1'b0;
  res_item_t         verdict;

  mesh_duplicate_broadcast_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .item_i      (pkt),
    .empty       (empty),
    .pop         (pop),
    .result_o    (verdict)
  );

  // Local copy of registers and filter state
  logic        mode_q;
  logic [15:0] bcast_q;
  logic [15:0] sender_addr [KNOWN_SENDERS];
  logic [14:0] colors_q;
  logic [63:0] seen_pairs [HISTORY_DEPTH];
  int          seen_fill;
  int          seen_oldest;
  logic [15:0] conc_addr;
  logic [15:0] hit_count [KNOWN_SENDERS];

  res_item_t   expected_verdicts [$];
  logic [63:0] recent_pairs [$];
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_cycles   = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("mesh_duplicate_broadcast_filter regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Filter model
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    mode_q      = 1'b0;
    bcast_q     = BCAST_RESET;
    colors_q    = COLOR_RESET;
    seen_fill   = 0;
    seen_oldest = 0;
    conc_addr   = BCAST_RESET;
    for (int i = 0; i < KNOWN_SENDERS; i++) begin
      sender_addr[i] = SENDER_RESET[i];
      hit_count[i]   = '0;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_MODE:     mode_q         = data[0];
      CFG_BCAST:    bcast_q        = data;
      CFG_SENDER_A: sender_addr[0] = data;
      CFG_SENDER_B: sender_addr[1] = data;
      CFG_SENDER_C: sender_addr[2] = data;
      CFG_SENDER_D: sender_addr[3] = data;
      CFG_COLORS:   colors_q       = data[14:0];
      default: ;
    endcase
  endfunction

  // Only live entries are searched, oldest first
  function automatic bit history_holds(logic [63:0] pair);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < seen_fill; k++) begin
      if (seen_pairs[(seen_oldest + k) % HISTORY_DEPTH] == pair) hit = 1'b1;
    end
    return hit;
  endfunction

  // Append, overwriting the oldest entry once full
  function automatic void remember_pair(logic [63:0] pair);
    if (seen_fill < HISTORY_DEPTH) begin
      seen_pairs[(seen_oldest + seen_fill) % HISTORY_DEPTH] = pair;
      seen_fill++;
    end else begin
      seen_pairs[seen_oldest] = pair;
      seen_oldest = (seen_oldest + 1) % HISTORY_DEPTH;
    end
  endfunction

  function automatic res_item_t filter_packet(in_item_t it);
    res_item_t   r;
    logic [63:0] pair;
    logic [15:0] snd;
    bit          bcast;
    bit          uniq;
    bit          found;
    r             = '0;
    r.sender_slot = UNKNOWN_SLOT;
    pair          = {it.payload_sender, it.payload_counter};
    bcast         = (it.packet_destination == bcast_q);
    uniq          = 1'b0;
    if (it.cmd == CMD_RECORD) begin
      remember_pair(pair);
    end else begin
      // endpoints pass unicast traffic straight through
      if (!mode_q && !bcast) begin
        uniq = 1'b1;
      end else if (!history_holds(pair)) begin
        uniq         = 1'b1;
        r.retransmit = !mode_q;
        remember_pair(pair);
      end
      r.is_unique = uniq;
      if (uniq && it.payload_size < MIN_PAYLOAD) begin
        r.size_error = 1'b1;
      end else if (uniq) begin
        snd = it.payload_sender[15:0];
        if (bcast) conc_addr = snd;
        r.indicate  = 1'b1;
        r.led_color = colors_q[14:12];
        found       = 1'b0;
        // lowest matching slot wins
        for (int i = 0; i < KNOWN_SENDERS; i++) begin
          if (!found && sender_addr[i] == snd) begin
            found          = 1'b1;
            hit_count[i]   = hit_count[i] + 16'd1;
            r.led_color    = colors_q[3*i +: 3];
            r.sender_slot  = 3'(i);
            r.sender_count = hit_count[i];
          end
        end
      end
    end
    r.concentrator_address = conc_addr;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop pacing and checking
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, actual %h", $time, verdict);
      end else begin
        want = expected_verdicts.pop_front();
        check_field("is_unique", want.is_unique, verdict.is_unique);
        check_field("retransmit", want.retransmit, verdict.retransmit);
        check_field("size_error", want.size_error, verdict.size_error);
        check_field("indicate", want.indicate, verdict.indicate);
        check_field("led_color", want.led_color, verdict.led_color);
        check_field("sender_slot", want.sender_slot, verdict.sender_slot);
        check_field("sender_count", want.sender_count, verdict.sender_count);
        check_field("concentrator_address", want.concentrator_address,
                    verdict.concentrator_address);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Entered and left at a falling edge; push stays high for a following item
  task automatic offer_packet(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    pkt  <= it;
    do @(posedge clk_i); while (full);
    expected_verdicts.insert(expected_verdicts.size(), filter_packet(it));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t mk_pkt(logic cmd, logic [15:0] dst, logic [31:0] cnt,
                                      logic [31:0] snd, logic [7:0] size);
    in_item_t it;
    it.cmd                = cmd;
    it.packet_destination = dst;
    it.payload_counter    = cnt;
    it.payload_sender     = snd;
    it.payload_size       = size;
    return it;
  endfunction

  // Mostly broadcasts from known senders, with replays of recent pairs
  function automatic in_item_t make_packet();
    in_item_t    it;
    logic [63:0] pair;
    int          r;
    it.cmd = ($urandom_range(99) < 10) ? CMD_RECORD : CMD_RECEIVE;
    r = $urandom_range(99);
    if (r < 60) it.packet_destination = bcast_q;
    else if (r < 65) it.packet_destination = 16'hFFFF;
    else it.packet_destination = 16'($urandom);
    r = $urandom_range(99);
    if (r < 30 && recent_pairs.size() > 0) begin
      pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
    end else begin
      pair[31:0]  = $urandom;
      pair[63:32] = $urandom;
      if (r < 75) pair[47:32] = sender_addr[$urandom_range(KNOWN_SENDERS - 1)];
      recent_pairs.insert(recent_pairs.size(), pair);
      if (recent_pairs.size() > RECENT_MAX) void'(recent_pairs.pop_front());
    end
    it.payload_counter = pair[31:0];
    it.payload_sender  = pair[63:32];
    it.payload_size    = ($urandom_range(99) < 15) ? 8'($urandom_range(7))
                                                   : 8'($urandom_range(255, 8));
    return it;
  endfunction

  task automatic randomize_registers(input logic mode);
    logic [15:0] addr [KNOWN_SENDERS];
    write_reg(CFG_MODE, {15'($urandom), mode});
    write_reg(CFG_BCAST, $urandom_range(1) ? 16'hFFFF : 16'($urandom));
    for (int i = 0; i < KNOWN_SENDERS; i++) begin
      addr[i] = (i > 0 && $urandom_range(3) == 0) ? addr[i-1] : 16'($urandom);
      write_reg(CFG_IW'(CFG_SENDER_A + i), addr[i]);
    end
    write_reg(CFG_COLORS, 16'($urandom));
    if ($urandom_range(1)) write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers, endpoint mode
  task automatic test_endpoint_basics();
    send_idle_pct = 0;
    stall_pct     = 0;
    // own broadcast recorded, then heard back as a duplicate
    offer_packet(mk_pkt(CMD_RECORD, 16'h1234, 32'h1, 32'h0000_8C18, 8'd20));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h1, 32'h0000_8C18, 8'd20));
    // each known slot sighted, the first one then replayed
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h2, 32'h0000_8C18, 8'd8));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h2, 32'h0000_8C18, 8'd8));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h3, 32'hABCD_7200, 8'd255));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'hFFFF_FFFF, 32'h0000_CD00, 8'd64));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h5, 32'h0000_5384, 8'd9));
    // unknown sender at the field extremes
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd200));
    // unicast bypass: not stored, so unique every time
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h0000, 32'h7, 32'h0000_7200, 8'd0));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h0000, 32'h7, 32'h0000_7200, 8'd0));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h0000, 32'h7, 32'h0000_7200, 8'd8));
    // short broadcast is still stored
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h0, 32'h0, 8'd7));
    offer_packet(mk_pkt(CMD_RECEIVE, BCAST_RESET, 32'h0, 32'h0, 8'd8));
    wait_idle();
  endtask

  // Every register at its limits, concentrator mode, repeated slot addresses
  task automatic test_register_extremes();
    write_reg(CFG_MODE, 16'hFFFF);
    write_reg(CFG_BCAST, 16'h0000);
    write_reg(CFG_SENDER_A, 16'hFFFF);
    write_reg(CFG_SENDER_B, 16'hFFFF);
    write_reg(CFG_SENDER_C, 16'hFFFF);
    write_reg(CFG_SENDER_D, 16'hFFFF);
    write_reg(CFG_COLORS, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'h1234);
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h5555, 32'h10, 32'h0000_FFFF, 8'd9));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h5555, 32'h10, 32'h0000_FFFF, 8'd9));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h0000, 32'h11, 32'h0000_0000, 8'd30));
    offer_packet(mk_pkt(CMD_RECORD, 16'hFFFF, 32'h12, 32'h0000_FFFF, 8'd3));
    wait_idle();
    write_reg(CFG_MODE, 16'h0000);
    write_reg(CFG_BCAST, 16'hFFFF);
    write_reg(CFG_SENDER_A, 16'h0000);
    write_reg(CFG_SENDER_B, 16'h0000);
    write_reg(CFG_SENDER_C, 16'h0000);
    write_reg(CFG_SENDER_D, 16'h0000);
    write_reg(CFG_COLORS, 16'h0000);
    offer_packet(mk_pkt(CMD_RECEIVE, 16'hFFFF, 32'h13, 32'h0001_0000, 8'd8));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'h0000, 32'h13, 32'h0001_0000, 8'd8));
    offer_packet(mk_pkt(CMD_RECEIVE, 16'hFFFF, 32'h12, 32'h0000_FFFF, 8'd8));
    wait_idle();
  endtask

  // Random traffic in both modes under each idle/stall profile
  task automatic test_random_traffic();
    int idle_tab  [4] = '{0, 67, 0, 29};
    int stall_tab [4] = '{0, 0, 67, 29};
    for (int p = 0; p < 8; p++) begin
      randomize_registers(p % 2);
      send_idle_pct = idle_tab[p/2];
      stall_pct     = stall_tab[p/2];
      for (int k = 0; k < 115; k++) offer_packet(make_packet());
      wait_idle();
    end
  endtask

  // Receiver holds off while the sender keeps offering: input must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    for (int k = 0; k < 20; k++) offer_packet(make_packet());
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_endpoint_basics();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (expected_verdicts.size() != 0) errors++;
    if (errors == 0) begin
      $display("mesh_duplicate_broadcast_filter regression: pass");
    end else begin
      $display("mesh_duplicate_broadcast_filter regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mdbf_pkg.sv
sv/mdbf_front.sv
sv/mdbf_back.sv
sv/mesh_duplicate_broadcast_filter.sv
tb/tb.sv
